// ===== rtl/spdf_pkg.sv =====
// Package for the two-class strict priority queue.
// Holds the entry type, status and action codes and reset constants.
// No dependencies.
package spdf_pkg;

  localparam int DEF_MAX_DEPTH = 16;
  localparam int CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spdf_status_t;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef struct packed {
    logic [15:0] high;
    logic [63:0] low;
  } spdf_entry_t;

endpackage

// ===== rtl/spdf_store.sv =====
// Entry memory for both rings: ring select in the top address bit.
// One write port, one read port with registered read data.
// Depends on spdf_pkg.
module spdf_store import spdf_pkg::*; #(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic        clk,
  input  logic        we,
  input  logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1):0] waddr,
  input  spdf_entry_t wdata,
  input  logic        re,
  input  logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1):0] raddr,
  output spdf_entry_t rdata
);

  localparam int PW        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int MEM_DEPTH = 2 * (1 << PW);

  spdf_entry_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/strict_priority_dual_fifo.sv =====
// Two-class strict priority queue: out_valid rises in the cycle after an input is accepted.
// Throughput one item per cycle; in_ready is high whenever the result register
// is empty or being taken in the same cycle, so a stalled output stalls input.
// Synchronous active-high reset: pointers and counts zero, capacity 16,
// no result pending. Entry memory is not cleared.
module strict_priority_dual_fifo import spdf_pkg::*; #(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic             is_priority,
  input  logic [63:0]      payload_low,
  input  logic [15:0]      payload_high,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic             from_priority,
  output logic [3:0]       slot_index,
  output logic [63:0]      out_payload_low,
  output logic [15:0]      out_payload_high
);

  localparam int PW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNTW = $clog2(MAX_DEPTH + 1);

  logic [CAP_W-1:0] capacity;
  logic [PW-1:0]    n_wptr, n_rptr, p_wptr, p_rptr;
  logic [PW-1:0]    n_wptr_next, n_rptr_next, p_wptr_next, p_rptr_next;
  logic [CNTW-1:0]  n_cnt, p_cnt, n_cnt_next, p_cnt_next;
  logic [CNTW-1:0]  cap_eff;
  logic [CNTW:0]    total;

  spdf_status_t     res_status, out_status;
  logic             res_prio, out_from_prio;
  logic [PW-1:0]    res_slot;
  logic [3:0]       out_slot;
  logic             res_pop, out_pop;
  logic             wr_en, rd_en;
  logic [PW:0]      wr_addr, rd_addr;
  logic             in_fire;
  spdf_entry_t      wr_entry, rd_entry;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CNTW-1:0] cap);
    logic [PW:0] n;
    n = {1'b0, p} + 1'b1;
    if (32'(n) >= 32'(cap)) return '0;
    return n[PW-1:0];
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // zero acts as one, anything above the ring size acts as the ring size
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNTW'(1);
    end else if (32'(capacity) > MAX_DEPTH) begin
      cap_eff = CNTW'(MAX_DEPTH);
    end else begin
      cap_eff = CNTW'(capacity);
    end
  end

  assign total = {1'b0, n_cnt} + {1'b0, p_cnt};

  always_comb begin
    n_wptr_next = n_wptr;
    n_rptr_next = n_rptr;
    p_wptr_next = p_wptr;
    p_rptr_next = p_rptr;
    n_cnt_next  = n_cnt;
    p_cnt_next  = p_cnt;
    res_status  = ST_DONE;
    res_prio    = 1'b0;
    res_slot    = '0;
    res_pop     = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = '0;
    rd_addr     = '0;
    if (action == ACT_PUSH) begin
      if (total >= {1'b0, cap_eff}) begin
        res_status = ST_FULL;
      end else if (is_priority) begin
        res_slot    = p_wptr;
        res_prio    = 1'b1;
        p_wptr_next = adv(p_wptr, cap_eff);
        p_cnt_next  = p_cnt + 1'b1;
        wr_en       = 1'b1;
        wr_addr     = {1'b1, p_wptr};
      end else begin
        res_slot    = n_wptr;
        n_wptr_next = adv(n_wptr, cap_eff);
        n_cnt_next  = n_cnt + 1'b1;
        wr_en       = 1'b1;
        wr_addr     = {1'b0, n_wptr};
      end
    end else begin
      priority if (p_cnt != '0) begin
        res_slot    = p_rptr;
        res_prio    = 1'b1;
        res_pop     = 1'b1;
        p_rptr_next = adv(p_rptr, cap_eff);
        p_cnt_next  = p_cnt - 1'b1;
        rd_en       = 1'b1;
        rd_addr     = {1'b1, p_rptr};
      end else if (n_cnt != '0) begin
        res_slot    = n_rptr;
        res_pop     = 1'b1;
        n_rptr_next = adv(n_rptr, cap_eff);
        n_cnt_next  = n_cnt - 1'b1;
        rd_en       = 1'b1;
        rd_addr     = {1'b0, n_rptr};
      end else begin
        res_status = ST_EMPTY;
      end
    end
  end

  assign wr_entry = '{high: payload_high, low: payload_low};

  spdf_store #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (in_fire && wr_en),
    .waddr(wr_addr),
    .wdata(wr_entry),
    .re   (in_fire && rd_en),
    .raddr(rd_addr),
    .rdata(rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_wptr <= '0;
      n_rptr <= '0;
      p_wptr <= '0;
      p_rptr <= '0;
      n_cnt  <= '0;
      p_cnt  <= '0;
    end else if (in_fire) begin
      n_wptr <= n_wptr_next;
      n_rptr <= n_rptr_next;
      p_wptr <= p_wptr_next;
      p_rptr <= p_rptr_next;
      n_cnt  <= n_cnt_next;
      p_cnt  <= p_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result fields; payload comes straight from the memory read register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status    <= res_status;
      out_from_prio <= res_prio;
      out_slot      <= 4'(res_slot);
      out_pop       <= res_pop;
    end
  end

  assign status           = out_status;
  assign from_priority    = out_from_prio;
  assign slot_index       = out_slot;
  assign out_payload_low  = out_pop ? rd_entry.low  : 64'd0;
  assign out_payload_high = out_pop ? rd_entry.high : 16'd0;

endmodule

// ===== rtl/spdf_checker.sv =====
// Port-level checks for strict_priority_dual_fifo, bound to the top level.
// Depends on spdf_pkg.
module spdf_checker import spdf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             action,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       status,
  input logic             from_priority,
  input logic [3:0]       slot_index,
  input logic [63:0]      out_payload_low,
  input logic [15:0]      out_payload_high
);

  // every accepted item shows its result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // a stalled result blocks the input side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // a refused operation reports nothing besides its code
  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_EMPTY) |->
      !from_priority && slot_index == 4'd0 &&
      out_payload_low == 64'd0 && out_payload_high == 16'd0)
    else $error("refused item carries data");

  // only a pop can return payload
  a_push_no_data: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_PUSH |=>
      out_payload_low == 64'd0 && out_payload_high == 16'd0)
    else $error("push returned payload");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index))
    else $error("stalled result changed");

endmodule

bind strict_priority_dual_fifo spdf_checker u_spdf_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for strict_priority_dual_fifo: push/pop items with random idling on
// both sides, each result checked against a behavioral two-ring queue model.
// Depends on spdf_pkg and the strict_priority_dual_fifo RTL.
module testbench;
  import spdf_pkg::*;

  localparam int DEPTH       = DEF_MAX_DEPTH;
  localparam int IDLE_PCT    = 23;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int BURST_LEN   = 32;

  typedef struct {
    spdf_status_t status;
    logic         from_prio;
    logic [3:0]   slot;
    spdf_entry_t  data;
  } op_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             action = ACT_PUSH;
  logic             is_priority = 1'b0;
  logic [63:0]      payload_low = '0;
  logic [15:0]      payload_high = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       status;
  logic             from_priority;
  logic [3:0]       slot_index;
  logic [63:0]      out_payload_low;
  logic [15:0]      out_payload_high;

  bit calm = 1'b0;  // no idling on either side while set
  int errors = 0;

  // queue model state
  logic [CAP_W-1:0] cap_reg = CAP_RESET;
  spdf_entry_t      norm_ring [DEPTH];
  spdf_entry_t      prio_ring [DEPTH];
  int               norm_wr = 0, norm_rd = 0, norm_cnt = 0;
  int               prio_wr = 0, prio_rd = 0, prio_cnt = 0;
  op_result_t       expected_results [$];

  strict_priority_dual_fifo dut (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .in_valid, .in_ready, .action, .is_priority, .payload_low, .payload_high,
    .out_valid, .out_ready, .status, .from_priority, .slot_index,
    .out_payload_low, .out_payload_high
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic int eff_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  // pointers wrap at the capacity in force when they are used
  function automatic int next_slot(int p);
    return (p + 1 >= eff_capacity()) ? 0 : p + 1;
  endfunction

  function automatic op_result_t predict_op(logic act, logic prio, spdf_entry_t e);
    op_result_t r;
    r.status    = ST_DONE;
    r.from_prio = 1'b0;
    r.slot      = '0;
    r.data      = '0;
    if (act == ACT_PUSH) begin
      if (norm_cnt + prio_cnt >= eff_capacity()) begin
        r.status = ST_FULL;
      end else if (prio) begin
        prio_ring[prio_wr] = e;
        r.from_prio = 1'b1;
        r.slot = 4'(prio_wr);
        prio_wr = next_slot(prio_wr);
        prio_cnt++;
      end else begin
        norm_ring[norm_wr] = e;
        r.slot = 4'(norm_wr);
        norm_wr = next_slot(norm_wr);
        norm_cnt++;
      end
    end else if (prio_cnt > 0) begin
      r.data = prio_ring[prio_rd];
      r.from_prio = 1'b1;
      r.slot = 4'(prio_rd);
      prio_rd = next_slot(prio_rd);
      prio_cnt--;
    end else if (norm_cnt > 0) begin
      r.data = norm_ring[norm_rd];
      r.slot = 4'(norm_rd);
      norm_rd = next_slot(norm_rd);
      norm_cnt--;
    end else begin
      r.status = ST_EMPTY;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    end
  endtask

  always @(posedge clk) begin : result_check
    op_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = expected_results.pop_front();
        check_field("status", status, want.status);
        check_field("from_priority", from_priority, want.from_prio);
        check_field("slot_index", slot_index, want.slot);
        check_field("out_payload_low", out_payload_low, want.data.low);
        check_field("out_payload_high", out_payload_high, want.data.high);
      end
    end
  end

  // Valid stays high between back-to-back items; it only drops for a gap.
  task automatic send_item(logic act, logic prio, logic [63:0] lo, logic [15:0] hi);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < IDLE_PCT);
    end
    in_valid     <= 1'b1;
    action       <= act;
    is_priority  <= prio;
    payload_low  <= lo;
    payload_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_op(act, prio, {hi, lo}));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cap_reg = v;
    cfg_we <= 1'b0;
  endtask

  task automatic test_empty_pop();
    send_item(ACT_POP, 1'b0, '0, '0);
    send_item(ACT_POP, 1'b1, '1, '1);  // class and payload ignored on pop
  endtask

  task automatic test_extreme_entries();
    send_item(ACT_PUSH, 1'b0, '1, '1);
    send_item(ACT_PUSH, 1'b1, '0, '0);
    send_item(ACT_PUSH, 1'b0, 64'h0123_4567_89AB_CDEF, 16'hA5C3);
    send_item(ACT_PUSH, 1'b1, 64'hAAAA_5555_AAAA_5555, 16'h5AA5);
    // priority entries come out first, then normal in order
    repeat (5) send_item(ACT_POP, 1'b0, '0, '0);
  endtask

  // Writes every slot of both rings, so later capacity changes never expose
  // a slot that was never written.
  task automatic test_fill_rings();
    set_capacity(5'd16);
    repeat (DEPTH) send_item(ACT_PUSH, 1'b1, {$urandom, $urandom}, 16'($urandom));
    send_item(ACT_PUSH, 1'b0, {$urandom, $urandom}, 16'($urandom));
    send_item(ACT_PUSH, 1'b1, {$urandom, $urandom}, 16'($urandom));
    repeat (DEPTH) send_item(ACT_POP, 1'b0, '0, '0);
    repeat (DEPTH) send_item(ACT_PUSH, 1'b0, {$urandom, $urandom}, 16'($urandom));
    send_item(ACT_PUSH, 1'b1, '1, '1);
    repeat (DEPTH + 1) send_item(ACT_POP, 1'b1, '0, '0);
  endtask

  task automatic test_capacity_limits();
    set_capacity(5'd1);
    send_item(ACT_PUSH, 1'b1, 64'hFEDC_BA98_7654_3210, 16'h1234);
    send_item(ACT_PUSH, 1'b0, '1, '1);
    send_item(ACT_POP, 1'b0, '0, '0);
    send_item(ACT_PUSH, 1'b0, 64'h1, 16'h8000);
    send_item(ACT_POP, 1'b0, '0, '0);
    // zero acts as one
    set_capacity(5'd0);
    send_item(ACT_PUSH, 1'b0, '1, 16'h0001);
    send_item(ACT_PUSH, 1'b1, '0, '1);
    send_item(ACT_POP, 1'b0, '0, '0);
    // values above the depth act as the depth
    set_capacity(5'd31);
    send_item(ACT_PUSH, 1'b1, 64'h8000_0000_0000_0000, 16'hFFFF);
    send_item(ACT_POP, 1'b0, '0, '0);
  endtask

  // Lower the capacity below the stored fill: pushes refused until drained,
  // pointers above the new capacity wrap to zero after their next use.
  task automatic test_capacity_lowered();
    set_capacity(5'd16);
    repeat (5) send_item(ACT_PUSH, 1'b0, {$urandom, $urandom}, 16'($urandom));
    repeat (3) send_item(ACT_PUSH, 1'b1, {$urandom, $urandom}, 16'($urandom));
    set_capacity(5'd3);
    send_item(ACT_PUSH, 1'b1, '1, '1);
    repeat (9) send_item(ACT_POP, 1'b0, '0, '0);
    repeat (2) send_item(ACT_PUSH, 1'b0, {$urandom, $urandom}, 16'($urandom));
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] cap_choice;
    logic [63:0]      lo;
    logic [15:0]      hi;
    logic             act;
    int               push_pct;
    int               pick;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       cap_choice = 5'd16;
        1:       cap_choice = 5'd1;
        2:       cap_choice = 5'd31;
        3:       cap_choice = 5'd0;
        4:       cap_choice = 5'd2;
        default: cap_choice = CAP_W'($urandom_range(31));
      endcase
      // capacity changes here with entries still stored
      set_capacity(cap_choice);
      calm = (ph == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // alternate push-heavy and pop-heavy bursts to reach full and empty
        push_pct = (((i / BURST_LEN) + ph) % 2 == 0) ? 80 : 25;
        act = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
        pick = $urandom_range(7);
        lo = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
        hi = (pick == 0) ? '0 : (pick == 1) ? '1 : 16'($urandom);
        send_item(act, 1'($urandom_range(1)), lo, hi);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pop();
    test_extreme_entries();
    test_fill_rings();
    test_capacity_limits();
    test_capacity_lowered();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
